FILE: rtl/core/frc_pkg.sv
// Types and codes shared by the flow record cache modules.
// No dependencies.
package frc_pkg;

  typedef enum logic [1:0] {
    CMD_PACKET  = 2'd0,
    CMD_COLLECT = 2'd1,
    CMD_FLUSH   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_UNKNOWN  = 2'd0,
    DIR_INBOUND  = 2'd1,
    DIR_OUTBOUND = 2'd2,
    DIR_INVALID  = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_WRD,
    ST_WCHK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [63:0] addresses;
    logic [31:0] ports;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [63:0] start_time;
    logic [63:0] last_time;
    logic [63:0] packets;
    logic [63:0] bytes_all;
    logic [63:0] bytes_in;
    logic [63:0] bytes_out;
    logic [1:0]  direction;
    logic [31:0] pid;
  } rec_t;

  localparam logic [63:0] EMIT_INTERVAL_RESET = 64'd1000000;

endpackage

FILE: rtl/core/frc_key_cam.sv
// Valid bits and flow keys held in flip-flops, compared in parallel.
// Depends on frc_pkg.
module frc_key_cam import frc_pkg::*; #(
  parameter int FLOW_ENTRIES = 64,
  localparam int IDX_W = $clog2(FLOW_ENTRIES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_idx,
  input  key_t                    wr_key,
  input  logic                    clr_en,
  input  logic [IDX_W-1:0]        clr_idx,
  input  key_t                    look_key,
  output logic                    hit,
  output logic [IDX_W-1:0]        hit_idx,
  output logic                    free_avail,
  output logic [IDX_W-1:0]        free_idx,
  output logic [FLOW_ENTRIES-1:0] valid
);

  key_t keys [FLOW_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (clr_en) valid[clr_idx] <= 1'b0;
      if (wr_en) valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) keys[wr_idx] <= wr_key;
  end

  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_avail = 1'b0;
    free_idx   = '0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == look_key) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_avail = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

endmodule

FILE: rtl/core/frc_rec_mem.sv
// Synchronous record memory, one write and one registered read per cycle.
// Depends on frc_pkg.
module frc_rec_mem import frc_pkg::*; #(
  parameter int FLOW_ENTRIES = 64,
  localparam int IDX_W = $clog2(FLOW_ENTRIES)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  rec_t             wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output rec_t             rdata
);

  rec_t mem [FLOW_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/flow_record_cache.sv
// Flow record cache top level: command sequencer, key CAM and record memory.
// Depends on frc_pkg, frc_key_cam and frc_rec_mem.
// A packet item goes through accept, key match with record read, and record
// write-back; it is dropped when its key misses and no slot is free. Collect
// and flush walk every slot in order, with one record memory read per used
// slot, and end in a final state; records leave through a one-item output
// register, so a stalled consumer holds the walk. The item after a command is
// accepted once its walk has ended. Unknown commands are accepted and dropped.
module flow_record_cache import frc_pkg::*; #(
  parameter int FLOW_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cmd, timestamp, protocol, local_addr, local_port, remote_addr,
  // remote_port, packet_bytes, direction, pid, zero pad
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // start_time, last_time, flow_protocol, address_pair, port_pair,
  // packet_count, bytes_total, bytes_in, bytes_out, flow_direction,
  // flow_pid, zero pad
  output logic [527:0] m_tdata,
  output logic         m_tlast
);

  localparam int IDX_W = $clog2(FLOW_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  state_t state, state_next;
  logic [63:0] emit_interval;
  cmd_t cmd_q;
  logic [63:0] now_q;
  key_t key_q;
  logic [15:0] bytes_q;
  logic [1:0] dir_q;
  logic [31:0] pid_q;
  logic [IDX_W-1:0] idx;
  logic hit_q;
  rec_t pend;
  logic pend_v;
  rec_t out_rec;

  logic cam_hit, cam_free;
  logic [IDX_W-1:0] cam_hit_idx, cam_free_idx;
  logic [FLOW_ENTRIES-1:0] valid;
  rec_t rd, upd;
  logic mem_re, mem_we;
  logic [IDX_W-1:0] mem_raddr;
  logic out_free, elig, take, push_pend, fin_push;
  logic [1:0] in_dir;
  rec_t base;

  frc_key_cam #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_cam (
    .clk(clk), .rst(rst),
    .wr_en(mem_we), .wr_idx(idx), .wr_key(key_q),
    .clr_en(take), .clr_idx(idx),
    .look_key(key_q),
    .hit(cam_hit), .hit_idx(cam_hit_idx),
    .free_avail(cam_free), .free_idx(cam_free_idx),
    .valid(valid)
  );

  frc_rec_mem #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(idx), .wdata(upd),
    .re(mem_re), .raddr(mem_raddr), .rdata(rd)
  );

  assign out_free = !m_tvalid || m_tready;
  assign elig = (cmd_q == CMD_FLUSH) ||
                (now_q >= rd.last_time && (now_q - rd.last_time) >= emit_interval) ||
                (now_q >= rd.start_time && (now_q - rd.start_time) >= emit_interval);
  assign in_dir = (s_tdata[187:186] == DIR_INVALID) ? DIR_UNKNOWN : s_tdata[187:186];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (cmd_t'(s_tdata[1:0]))
            CMD_PACKET:  state_next = ST_LOOK;
            CMD_COLLECT: state_next = ST_WRD;
            CMD_FLUSH:   state_next = ST_WRD;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOOK: state_next = (cam_hit || cam_free) ? ST_UPD : ST_IDLE;
      ST_UPD:  state_next = ST_IDLE;
      ST_WRD: begin
        if (valid[idx]) state_next = ST_WCHK;
        else if (idx == LAST_IDX) state_next = ST_FIN;
      end
      ST_WCHK: begin
        if (!(elig && pend_v && !out_free)) state_next = (idx == LAST_IDX) ? ST_FIN : ST_WRD;
      end
      ST_FIN: begin
        if (!pend_v || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = idx;
    mem_we    = 1'b0;
    take      = 1'b0;
    push_pend = 1'b0;
    fin_push  = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_LOOK: begin
        mem_re    = 1'b1;
        mem_raddr = cam_hit ? cam_hit_idx : cam_free_idx;
      end
      ST_UPD:  mem_we = 1'b1;
      ST_WRD:  mem_re = valid[idx];
      ST_WCHK: begin
        take      = elig && (!pend_v || out_free);
        push_pend = take && pend_v;
      end
      ST_FIN:  fin_push = pend_v && out_free;
      default: ;
    endcase
  end

  always_comb begin
    base = rd;
    if (!hit_q) begin
      base            = '0;
      base.start_time = now_q;
    end
    upd           = base;
    upd.key       = key_q;
    upd.last_time = now_q;
    upd.packets   = sat_add(base.packets, 64'd1);
    upd.bytes_all = sat_add(base.bytes_all, {48'd0, bytes_q});
    upd.direction = dir_q;
    upd.pid       = pid_q;
    if (dir_q == DIR_INBOUND) upd.bytes_in = sat_add(base.bytes_in, {48'd0, bytes_q});
    if (dir_q == DIR_OUTBOUND) upd.bytes_out = sat_add(base.bytes_out, {48'd0, bytes_q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      emit_interval <= EMIT_INTERVAL_RESET;
      pend_v        <= 1'b0;
      m_tvalid      <= 1'b0;
      idx           <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) emit_interval <= cfg_wdata;
      if (s_tvalid && s_tready) idx <= '0;
      if (state == ST_LOOK) idx <= mem_raddr;
      if ((state == ST_WRD && !valid[idx] && idx != LAST_IDX) ||
          (state == ST_WCHK && state_next == ST_WRD)) begin
        idx <= idx + 1'b1;
      end
      if (take) pend_v <= 1'b1;
      else if (fin_push) pend_v <= 1'b0;
      if (push_pend || fin_push) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_q   <= cmd_t'(s_tdata[1:0]);
      now_q   <= s_tdata[65:2];
      key_q   <= '{protocol: s_tdata[73:66],
                   addresses: {s_tdata[105:74], s_tdata[153:122]},
                   ports: {s_tdata[121:106], s_tdata[169:154]}};
      bytes_q <= s_tdata[185:170];
      dir_q   <= in_dir;
      pid_q   <= s_tdata[219:188];
    end
    if (state == ST_LOOK) hit_q <= cam_hit;
    if (take) pend <= rd;
    if (push_pend || fin_push) begin
      out_rec <= pend;
      m_tlast <= fin_push;
    end
  end

  assign m_tdata = {6'd0, out_rec.pid, out_rec.direction, out_rec.bytes_out,
                    out_rec.bytes_in, out_rec.bytes_all, out_rec.packets,
                    out_rec.key.ports, out_rec.key.addresses, out_rec.key.protocol,
                    out_rec.last_time, out_rec.start_time};

  a_upd_sets_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD |=> valid[$past(idx)])
    else $error("updated slot not valid");

  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    take |=> !valid[$past(idx)])
    else $error("emitted slot still valid");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_v)
    else $error("record left pending after walk");

  a_no_push_busy: assert property (@(posedge clk) disable iff (rst)
    (push_pend || fin_push) |-> out_free)
    else $error("output overwritten");

endmodule

FILE: tb/flow_record_cache_test.sv
// Self-checking testbench for flow_record_cache: drives packet, collect and flush items,
// predicts every emitted flow record and compares it field by field.
// Depends on frc_pkg and the flow_record_cache RTL.
module flow_record_cache_test;
  import frc_pkg::*;

  typedef struct {
    cmd_t        cmd;
    bit [63:0]   stamp;
    bit [7:0]    proto;
    bit [31:0]   laddr;
    bit [15:0]   lport;
    bit [31:0]   raddr;
    bit [15:0]   rport;
    bit [15:0]   len;
    dir_t        dir;
    bit [31:0]   pid;
  } pkt_t;

  typedef struct {
    bit [63:0] start_time;
    bit [63:0] last_time;
    bit [7:0]  proto;
    bit [63:0] addrs;
    bit [31:0] ports;
    bit [63:0] packets;
    bit [63:0] bytes_all;
    bit [63:0] bytes_in;
    bit [63:0] bytes_out;
    bit [1:0]  dir;
    bit [31:0] pid;
    bit        last;
  } flow_rec_t;

  class flow_scoreboard;
    bit [63:0] interval;
    bit        used[64];
    flow_rec_t table_rec[64];
    flow_rec_t pending[$];
    int        errors;

    function new();
      interval = EMIT_INTERVAL_RESET;
      errors = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
      bit [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function bit aged(bit [63:0] now, bit [63:0] then);
      return now >= then && (now - then) >= interval;
    endfunction

    function void note_item(pkt_t p);
      int slot;
      int first;
      bit [63:0] addrs;
      bit [31:0] ports;
      bit [1:0] d;
      slot = -1;
      first = -1;
      addrs = {p.laddr, p.raddr};
      ports = {p.lport, p.rport};
      d = (p.dir == DIR_INVALID) ? DIR_UNKNOWN : p.dir;
      case (p.cmd)
        CMD_PACKET: begin
          for (int i = 0; i < 64; i++) begin
            if (slot < 0 && used[i] && table_rec[i].proto == p.proto &&
                table_rec[i].addrs == addrs && table_rec[i].ports == ports)
              slot = i;
          end
          if (slot < 0) begin
            for (int i = 0; i < 64; i++)
              if (slot < 0 && !used[i]) slot = i;
            if (slot < 0) return;
            used[slot] = 1;
            table_rec[slot] = '{default: 0};
            table_rec[slot].proto = p.proto;
            table_rec[slot].addrs = addrs;
            table_rec[slot].ports = ports;
            table_rec[slot].start_time = p.stamp;
          end
          table_rec[slot].last_time = p.stamp;
          table_rec[slot].packets = sat_add(table_rec[slot].packets, 64'd1);
          table_rec[slot].bytes_all = sat_add(table_rec[slot].bytes_all, {48'd0, p.len});
          table_rec[slot].dir = d;
          table_rec[slot].pid = p.pid;
          if (d == DIR_INBOUND)
            table_rec[slot].bytes_in = sat_add(table_rec[slot].bytes_in, {48'd0, p.len});
          else if (d == DIR_OUTBOUND)
            table_rec[slot].bytes_out = sat_add(table_rec[slot].bytes_out, {48'd0, p.len});
        end
        CMD_COLLECT, CMD_FLUSH: begin
          for (int i = 0; i < 64; i++) begin
            if (used[i] && (p.cmd == CMD_FLUSH || aged(p.stamp, table_rec[i].last_time) ||
                aged(p.stamp, table_rec[i].start_time))) begin
              table_rec[i].last = 0;
              pending = {pending, table_rec[i]};
              used[i] = 0;
              first = pending.size() - 1;
            end
          end
          if (first >= 0) pending[first].last = 1;
        end
        default: ;
      endcase
    endfunction

    function void cmp(string name, bit [63:0] want, bit [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [527:0] d, logic tl);
      flow_rec_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, actual %h", $time, d);
        return;
      end
      e = pending.pop_front();
      cmp("start_time", e.start_time, d[63:0]);
      cmp("last_time", e.last_time, d[127:64]);
      cmp("flow_protocol", {56'd0, e.proto}, {56'd0, d[135:128]});
      cmp("address_pair", e.addrs, d[199:136]);
      cmp("port_pair", {32'd0, e.ports}, {32'd0, d[231:200]});
      cmp("packet_count", e.packets, d[295:232]);
      cmp("bytes_total", e.bytes_all, d[359:296]);
      cmp("bytes_in", e.bytes_in, d[423:360]);
      cmp("bytes_out", e.bytes_out, d[487:424]);
      cmp("flow_direction", {62'd0, e.dir}, {62'd0, d[489:488]});
      cmp("flow_pid", {32'd0, e.pid}, {32'd0, d[521:490]});
      cmp("pad", 64'd0, {58'd0, d[527:522]});
      cmp("tlast", {63'd0, e.last}, {63'd0, tl});
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [63:0]  cfg_wdata = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [527:0] m_tdata;
  logic         m_tlast;

  flow_scoreboard sb = new();
  bit        calm = 0;
  bit [63:0] clock_now = 0;
  pkt_t      key_pool[$];
  int        idle_cycles = 0;

  flow_record_cache dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata, m_tlast);
    end
  end

  task automatic send(pkt_t p);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {4'b0, p.pid, p.dir, p.len, p.rport, p.raddr, p.lport, p.laddr,
                p.proto, p.stamp, p.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(p);
  endtask

  task automatic drain_wait();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    while (!s_tready) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_interval(bit [63:0] v);
    drain_wait();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.interval = v;
  endtask

  function automatic pkt_t rand_pkt(cmd_t c);
    pkt_t p;
    p.cmd = c;
    p.stamp = {$urandom, $urandom};
    p.proto = 8'($urandom);
    p.laddr = $urandom;
    p.lport = 16'($urandom);
    p.raddr = $urandom;
    p.rport = 16'($urandom);
    p.len = 16'($urandom);
    p.dir = dir_t'(2'($urandom_range(0, 3)));
    p.pid = $urandom;
    return p;
  endfunction

  function automatic pkt_t pool_pkt();
    pkt_t p;
    pkt_t k;
    p = rand_pkt(CMD_PACKET);
    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    p.proto = k.proto;
    p.laddr = k.laddr;
    p.lport = k.lport;
    p.raddr = k.raddr;
    p.rport = k.rport;
    return p;
  endfunction

  task automatic random_phase(int count, int pool_size);
    pkt_t p;
    int r;
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) key_pool = {key_pool, rand_pkt(CMD_PACKET)};
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) p = pool_pkt();
      else if (r < 75) p = rand_pkt(CMD_PACKET);
      else if (r < 90) p = rand_pkt(CMD_COLLECT);
      else if (r < 94) p = rand_pkt(CMD_FLUSH);
      else p = rand_pkt(CMD_NONE);
      if ($urandom_range(0, 19) != 0) begin
        clock_now = clock_now + 64'($urandom_range(0, 40));
        p.stamp = clock_now;
      end
      send(p);
      if ($urandom_range(0, 49) == 0) calm = !calm;
    end
  endtask

  initial begin
    pkt_t p;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    p = '{cmd: CMD_PACKET, dir: DIR_UNKNOWN, default: 0};
    send(p);
    p = '{cmd: CMD_PACKET, dir: DIR_INVALID, default: '1};
    send(p);
    p.stamp = 64'd3;
    p.dir = DIR_INBOUND;
    send(p);
    p.dir = DIR_OUTBOUND;
    p.len = 16'd7;
    send(p);
    send(rand_pkt(CMD_NONE));
    p = '{cmd: CMD_COLLECT, stamp: 64'd5, dir: DIR_UNKNOWN, default: 0};
    send(p);
    p.stamp = '1;
    send(p);
    p.cmd = CMD_FLUSH;
    send(p);
    p.cmd = CMD_COLLECT;
    send(p);
    for (int i = 0; i < 6; i++) begin
      p = rand_pkt(CMD_PACKET);
      p.stamp = 64'd100 + 64'(i);
      send(p);
    end
    p = rand_pkt(CMD_COLLECT);
    p.stamp = 64'd50;
    send(p);
    p.cmd = CMD_FLUSH;
    send(p);

    set_interval(64'd0);
    random_phase(80, 12);
    set_interval(64'd60);
    random_phase(120, 90);
    set_interval('1);
    random_phase(80, 70);
    set_interval(64'd200);
    random_phase(100, 8);
    set_interval(EMIT_INTERVAL_RESET);
    random_phase(80, 20);
    p = rand_pkt(CMD_FLUSH);
    send(p);

    drain_wait();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/frc_pkg.sv
rtl/core/frc_key_cam.sv
rtl/core/frc_rec_mem.sv
rtl/core/flow_record_cache.sv
tb/flow_record_cache_test.sv
